[src/olir_pkg.sv]
package olir_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned ElemWidthDef = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned IdxW         = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_INS_SHIFT = 3'd0,
    OP_REM_SHIFT = 3'd1,
    OP_INS_SWAP  = 3'd2,
    OP_REM_SWAP  = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_INS_SHIFT,
    CELL_REM_SHIFT,
    CELL_INS_SWAP,
    CELL_REM_SWAP
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_GATHER,
    FSM_APPLY
  } fsm_e;

  typedef struct packed {
    cell_op_e              op;
    logic [IdxW-1:0]       idx;
    logic [IdxW-1:0]       cnt;
  } cell_ctrl_t;

endpackage

[src/olir_cell.sv]
module olir_cell #(
  parameter int unsigned ELEM_WIDTH = olir_pkg::ElemWidthDef,
  parameter int unsigned INDEX      = 0
) (
  input  logic                   clk_i,
  input  olir_pkg::cell_ctrl_t   ctrl_i,
  input  logic [ELEM_WIDTH-1:0]  value_i,
  input  logic [ELEM_WIDTH-1:0]  pick_i,
  input  logic [ELEM_WIDTH-1:0]  last_i,
  input  logic [ELEM_WIDTH-1:0]  left_i,
  input  logic [ELEM_WIDTH-1:0]  right_i,
  output logic [ELEM_WIDTH-1:0]  data_o
);
  import olir_pkg::*;

  localparam logic [IdxW-1:0] Pos = IdxW'(INDEX);

  logic [ELEM_WIDTH-1:0] data_q, data_d;
  logic [IdxW-1:0]       last_pos;

  assign last_pos = ctrl_i.cnt - IdxW'(1);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INS_SHIFT: begin
        if (Pos == ctrl_i.idx) begin
          data_d = value_i;
        end else if (Pos > ctrl_i.idx && Pos <= ctrl_i.cnt) begin
          data_d = left_i;
        end
      end
      CELL_REM_SHIFT: begin
        if (Pos >= ctrl_i.idx && Pos < last_pos) begin
          data_d = right_i;
        end
      end
      CELL_INS_SWAP: begin
        if (Pos == ctrl_i.idx) begin
          data_d = value_i;
        end else if (Pos == ctrl_i.cnt) begin
          data_d = pick_i;
        end
      end
      CELL_REM_SWAP: begin
        if (Pos == ctrl_i.idx) begin
          data_d = last_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[src/ordered_list_insert_remove.sv]
// Ordered list of up to CAPACITY elements with insert/remove by index.
// Input channel (in_valid_i/in_ready_o) carries op_i, index_i, value_i;
// output channel (out_valid_o/out_ready_i) returns one beat per input beat
// with status_o, count_o and read_value_o, in order.
// Each input beat passes through an accept, a gather and an apply step: the
// index is clamped at accept, the gather step registers the element at the
// index and the last element from the cell row, and in the apply step the
// cells load their neighbor, the new value or a gathered element in parallel.
// The output register is loaded in the apply step; no new input beat is taken
// until the apply step of the current one is done.
// The output beat sits in an output register; the next input beat is taken
// while it waits. If the receiver stalls, the apply step holds until the
// output register is free and no further input is accepted.
// Reset empties the list (count zero); element storage is not cleared and
// never reads back before it is written.
module ordered_list_insert_remove #(
  parameter int unsigned CAPACITY   = olir_pkg::CapacityDef,
  parameter int unsigned ELEM_WIDTH = olir_pkg::ElemWidthDef,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [olir_pkg::OpW-1:0]      op_i,
  input  logic [olir_pkg::IdxW-1:0]     index_i,
  input  logic [olir_pkg::ValueW-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [olir_pkg::StatusW-1:0]  status_o,
  output logic [CNT_W-1:0]              count_o,
  output logic [olir_pkg::ValueW-1:0]   read_value_o
);
  import olir_pkg::*;

  fsm_e                  state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept, fire;

  cell_ctrl_t            dec_ctrl, ctrl_q, bcast;
  status_e               dec_status, status_q;
  logic                  dec_read, read_q;
  logic [IdxW-1:0]       cnt16;
  logic [ELEM_WIDTH-1:0] value_q;
  logic [ELEM_WIDTH-1:0] pick_d, pick_q, last_d, last_q;
  logic [IdxW-1:0]       last_pos;

  logic [StatusW-1:0]    status_out_q;
  logic [CNT_W-1:0]      count_out_q;
  logic [ValueW-1:0]     read_value_q;

  logic [ELEM_WIDTH-1:0] data [CAPACITY];

  assign in_ready_o = (state_q == FSM_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt16      = IdxW'(count_q);

  // clamp index and resolve refusals at accept
  always_comb begin
    dec_ctrl.op  = CELL_NONE;
    dec_ctrl.idx = index_i;
    dec_ctrl.cnt = cnt16;
    dec_status   = ST_OK;
    dec_read     = 1'b0;
    case (op_i)
      OP_INS_SHIFT, OP_INS_SWAP: begin
        if (count_q == CNT_W'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else begin
          dec_ctrl.op = (op_i == OP_INS_SHIFT) ? CELL_INS_SHIFT : CELL_INS_SWAP;
          if (index_i > cnt16) begin
            dec_ctrl.idx = cnt16;
          end
        end
      end
      OP_REM_SHIFT, OP_REM_SWAP: begin
        if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_ctrl.op = (op_i == OP_REM_SHIFT) ? CELL_REM_SHIFT : CELL_REM_SWAP;
          if (index_i > cnt16 - IdxW'(1)) begin
            dec_ctrl.idx = cnt16 - IdxW'(1);
          end
        end
      end
      OP_READ: begin
        if (index_i < cnt16) begin
          dec_read = 1'b1;
        end else begin
          dec_status = ST_RANGE;
        end
      end
      default: begin
        dec_ctrl.op = CELL_NONE;
      end
    endcase
  end

  // gather element at index and last element
  assign last_pos = ctrl_q.cnt - IdxW'(1);

  always_comb begin
    pick_d = '0;
    last_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ctrl_q.idx == IdxW'(i)) begin
        pick_d = pick_d | data[i];
      end
      if (last_pos == IdxW'(i)) begin
        last_d = last_d | data[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    fire        = 1'b0;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_GATHER;
        end
      end
      FSM_GATHER: begin
        state_d = FSM_APPLY;
      end
      FSM_APPLY: begin
        if (!out_valid_q || out_ready_i) begin
          fire        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
          case (ctrl_q.op)
            CELL_INS_SHIFT, CELL_INS_SWAP: count_d = count_q + CNT_W'(1);
            CELL_REM_SHIFT, CELL_REM_SWAP: count_d = count_q - CNT_W'(1);
            default:                       count_d = count_q;
          endcase
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    bcast = ctrl_q;
    if (!fire) begin
      bcast.op = CELL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q   <= dec_ctrl;
      status_q <= dec_status;
      read_q   <= dec_read;
      value_q  <= ELEM_WIDTH'(value_i);
    end
    if (state_q == FSM_GATHER) begin
      pick_q <= pick_d;
      last_q <= last_d;
    end
    if (fire) begin
      status_out_q <= status_q;
      count_out_q  <= count_d;
      read_value_q <= read_q ? ValueW'(pick_q) : '0;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_body
      assign right = data[g+1];
    end
    olir_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (bcast),
      .value_i (value_q),
      .pick_i  (pick_q),
      .last_i  (last_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[g])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_out_q;
  assign count_o      = count_out_q;
  assign read_value_o = read_value_q;

endmodule

[src/olir_checker.sv]
module olir_checker #(
  parameter int unsigned CAPACITY   = olir_pkg::CapacityDef,
  parameter int unsigned ELEM_WIDTH = olir_pkg::ElemWidthDef,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [olir_pkg::OpW-1:0]      op_i,
  input  logic [olir_pkg::IdxW-1:0]     index_i,
  input  logic [olir_pkg::ValueW-1:0]   value_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [olir_pkg::StatusW-1:0]  status_o,
  input  logic [CNT_W-1:0]              count_o,
  input  logic [olir_pkg::ValueW-1:0]   read_value_o
);
  import olir_pkg::*;

  localparam int unsigned ElemSpare = ELEM_WIDTH;

  logic unused;
  assign unused = ^{in_valid_i, in_ready_o, op_i, index_i, value_i} ^ (ElemSpare == 0);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(count_o)
                                    && $stable(read_value_o))
    else $error("output beat changed while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_o == '0)
    else $error("empty status with elements held");

  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0)
    else $error("read value not zero on error status");

endmodule

bind ordered_list_insert_remove olir_checker #(
  .CAPACITY   (CAPACITY),
  .ELEM_WIDTH (ELEM_WIDTH)
) u_olir_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .op_i         (op_i),
  .index_i      (index_i),
  .value_i      (value_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .count_o      (count_o),
  .read_value_o (read_value_o)
);
